// ----- rtl/core/csur_pkg.sv -----
// ----------------------------------------------------------------------------
// csur_pkg
// Shared types and constants of the counted sample upload receiver.
// ----------------------------------------------------------------------------
package csur_pkg;

  // Request codes on req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds on out_kind
  localparam logic [2:0] KIND_REQ     = 3'd0;
  localparam logic [2:0] KIND_SAMPLE  = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_BADCNT  = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // Byte sent to ask the far end for an upload
  localparam logic [7:0] REQUEST_BYTE = 8'hAA;

  // Hard ceiling on the accepted sample count
  localparam int MAX_SAMPLE_CAP = 4096;

  // Register map
  localparam int          ADDR_W         = 4;
  localparam logic [1:0]  REG_METHOD     = 2'd0;
  localparam logic [1:0]  REG_MAX_SAMP   = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT    = 2'd2;
  localparam logic        METHOD_RST     = 1'b1;
  localparam logic [12:0] MAX_SAMP_RST   = 13'd4096;
  localparam logic [15:0] TIMEOUT_RST    = 16'd200;

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic        sample_format;
    logic [12:0] max_samples;
    logic [15:0] byte_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [11:0] sample_number;
    logic [15:0] sample_index;
    logic [15:0] sample_pulses;
    logic [31:0] reported_count;
    logic        last;
  } res_t;

endpackage

// ----- rtl/core/csur_regs.sv -----
// ----------------------------------------------------------------------------
// csur_regs
// APB-style configuration registers: sample format, sample cap, byte timeout.
// ----------------------------------------------------------------------------
module csur_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csur_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output csur_pkg::cfg_t             cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format      <= csur_pkg::METHOD_RST;
      cfg.max_samples        <= csur_pkg::MAX_SAMP_RST;
      cfg.byte_timeout_ticks <= csur_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        csur_pkg::REG_METHOD:   cfg.sample_format      <= pwdata[0];
        csur_pkg::REG_MAX_SAMP: cfg.max_samples        <= pwdata[12:0];
        csur_pkg::REG_TIMEOUT:  cfg.byte_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      csur_pkg::REG_METHOD:   prdata = {31'd0, cfg.sample_format};
      csur_pkg::REG_MAX_SAMP: prdata = {19'd0, cfg.max_samples};
      csur_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg.byte_timeout_ticks};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/csur_front.sv -----
// ----------------------------------------------------------------------------
// csur_front
// Accepts requests, drops unknown codes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module csur_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     req_type,
  input  logic [7:0]     rx_byte,
  output logic           full,
  output logic           cmd_valid,
  output csur_pkg::cmd_t cmd,
  input  logic           cmd_pop
);

  csur_pkg::cmd_t                    q_mem [csur_pkg::CMD_DEPTH];
  logic [csur_pkg::CMD_PTR_W-1:0]    wr_ptr;
  logic [csur_pkg::CMD_PTR_W-1:0]    rd_ptr;
  logic [csur_pkg::CMD_CNT_W-1:0]    count;
  logic                              accept;
  logic                              known;
  logic                              wr_en;
  logic                              rd_en;

  assign full      = (count == csur_pkg::CMD_CNT_W'(csur_pkg::CMD_DEPTH));
  assign accept    = push & ~full;
  assign known     = (req_type == csur_pkg::REQ_START) ||
                     (req_type == csur_pkg::REQ_BYTE)  ||
                     (req_type == csur_pkg::REQ_TICK);
  assign wr_en     = accept & known;
  assign cmd_valid = (count != '0);
  assign rd_en     = cmd_pop & cmd_valid;
  assign cmd       = q_mem[rd_ptr];

  // Store classified requests
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr] <= '{op: req_type, data: rx_byte};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + csur_pkg::CMD_CNT_W'(wr_en) - csur_pkg::CMD_CNT_W'(rd_en);
    end
  end

endmodule

// ----- rtl/core/csur_back.sv -----
// ----------------------------------------------------------------------------
// csur_back
// Runs the upload state machine on queued requests and holds results in a
// two-entry output queue.
// ----------------------------------------------------------------------------
module csur_back (
  input  logic           clk,
  input  logic           rst,
  input  csur_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  csur_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output csur_pkg::res_t res
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_SAMPLES = 2'd2;

  logic [1:0]  phase,          phase_next;
  logic [31:0] count_accum,    count_accum_next;
  logic [1:0]  header_pos,     header_pos_next;
  logic [31:0] sample_shift,   sample_shift_next;
  logic [1:0]  byte_in_sample, byte_in_sample_next;
  logic [12:0] samples_done,   samples_done_next;
  logic [15:0] wait_ticks,     wait_ticks_next;

  csur_pkg::res_t res_mem [2];
  logic           res_wr_ptr;
  logic           res_rd_ptr;
  logic [1:0]     res_count;
  logic           res_push;
  logic           res_pop;
  csur_pkg::res_t res_new;

  logic           exec;
  logic [31:0]    cap;
  logic [31:0]    count_shift;
  logic [31:0]    shift_in;
  logic [1:0]     last_pos;
  logic [15:0]    ticks_inc;
  logic           is_last;

  assign res_pop = pop & ~empty;
  assign empty   = (res_count == 2'd0);
  assign exec    = cmd_valid & ((res_count != 2'd2) | res_pop);
  assign cmd_pop = exec;
  assign res     = res_mem[res_rd_ptr];

  assign cap = (32'(cfg.max_samples) > 32'(csur_pkg::MAX_SAMPLE_CAP)) ?
               32'(csur_pkg::MAX_SAMPLE_CAP) : 32'(cfg.max_samples);
  assign count_shift = {count_accum[23:0], cmd.data};
  assign shift_in    = {sample_shift[23:0], cmd.data};
  assign last_pos    = cfg.sample_format ? 2'd2 : 2'd3;
  assign ticks_inc   = (wait_ticks != 16'hFFFF) ? wait_ticks + 16'd1 : wait_ticks;
  assign is_last     = ((32'(samples_done) + 32'd1) >= count_accum);

  // Step the upload state on one request
  always_comb begin
    phase_next          = phase;
    count_accum_next    = count_accum;
    header_pos_next     = header_pos;
    sample_shift_next   = sample_shift;
    byte_in_sample_next = byte_in_sample;
    samples_done_next   = samples_done;
    wait_ticks_next     = wait_ticks;
    res_push            = 1'b0;
    res_new             = '0;
    if (exec) begin
      unique case (cmd.op)
        csur_pkg::REQ_START: begin
          phase_next          = PH_HEADER;
          count_accum_next    = 32'd0;
          header_pos_next     = 2'd0;
          sample_shift_next   = 32'd0;
          byte_in_sample_next = 2'd0;
          samples_done_next   = 13'd0;
          wait_ticks_next     = 16'd0;
          res_push            = 1'b1;
          res_new.out_kind    = csur_pkg::KIND_REQ;
          res_new.tx_byte     = csur_pkg::REQUEST_BYTE;
        end
        csur_pkg::REQ_BYTE: begin
          if (phase == PH_HEADER) begin
            wait_ticks_next  = 16'd0;
            count_accum_next = count_shift;
            header_pos_next  = header_pos + 2'd1;
            if (header_pos == 2'd3) begin
              if (count_shift == 32'd0) begin
                phase_next       = PH_IDLE;
                res_push         = 1'b1;
                res_new.out_kind = csur_pkg::KIND_EMPTY;
              end else if (count_shift > cap) begin
                phase_next             = PH_IDLE;
                res_push               = 1'b1;
                res_new.out_kind       = csur_pkg::KIND_BADCNT;
                res_new.reported_count = count_shift;
              end else begin
                phase_next          = PH_SAMPLES;
                samples_done_next   = 13'd0;
                byte_in_sample_next = 2'd0;
                sample_shift_next   = 32'd0;
              end
            end
          end else if (phase == PH_SAMPLES) begin
            wait_ticks_next = 16'd0;
            if (byte_in_sample < last_pos) begin
              sample_shift_next   = shift_in;
              byte_in_sample_next = byte_in_sample + 2'd1;
            end else begin
              res_push              = 1'b1;
              res_new.out_kind      = csur_pkg::KIND_SAMPLE;
              res_new.sample_number = samples_done[11:0];
              res_new.last          = is_last;
              if (cfg.sample_format) begin
                res_new.sample_index  = {6'd0, shift_in[23:14]};
                res_new.sample_pulses = {6'd0, shift_in[13:4]};
              end else begin
                res_new.sample_index  = shift_in[31:16];
                res_new.sample_pulses = shift_in[15:0];
              end
              samples_done_next   = samples_done + 13'd1;
              byte_in_sample_next = 2'd0;
              sample_shift_next   = 32'd0;
              if (is_last) begin
                phase_next      = PH_IDLE;
                header_pos_next = 2'd0;
              end
            end
          end
        end
        csur_pkg::REQ_TICK: begin
          if (phase != PH_IDLE) begin
            wait_ticks_next = ticks_inc;
            if (ticks_inc >= cfg.byte_timeout_ticks) begin
              phase_next          = PH_IDLE;
              header_pos_next     = 2'd0;
              byte_in_sample_next = 2'd0;
              sample_shift_next   = 32'd0;
              wait_ticks_next     = 16'd0;
              res_push            = 1'b1;
              res_new.out_kind    = csur_pkg::KIND_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold upload state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      count_accum    <= 32'd0;
      header_pos     <= 2'd0;
      sample_shift   <= 32'd0;
      byte_in_sample <= 2'd0;
      samples_done   <= 13'd0;
      wait_ticks     <= 16'd0;
    end else begin
      phase          <= phase_next;
      count_accum    <= count_accum_next;
      header_pos     <= header_pos_next;
      sample_shift   <= sample_shift_next;
      byte_in_sample <= byte_in_sample_next;
      samples_done   <= samples_done_next;
      wait_ticks     <= wait_ticks_next;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr_ptr] <= res_new;
    end
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_pop) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      res_count <= res_count + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule

// ----- rtl/core/counted_sample_upload_receiver.sv -----
// A request waits in the request queue; its result, if it has one, is registered
// into the result queue, whose head drives the result ports.
// Throughput: one request per cycle, sustained while results are popped.
// A four-entry request queue and a two-entry result queue absorb stalls.
// Reset (rst, synchronous): both queues empty, phase idle, registers to
// sample format 1, cap 4096, byte timeout 200 ticks.
// ----------------------------------------------------------------------------
// counted_sample_upload_receiver
// Receiver for a length-prefixed sample upload with per-byte timeout.
// ----------------------------------------------------------------------------
module counted_sample_upload_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type,
  input  logic [7:0]                  rx_byte,
  input  logic                        pop,
  output logic                        empty,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  tx_byte,
  output logic [11:0]                 sample_number,
  output logic [15:0]                 sample_index,
  output logic [15:0]                 sample_pulses,
  output logic [31:0]                 reported_count,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csur_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  csur_pkg::cfg_t cfg;
  csur_pkg::cmd_t cmd;
  csur_pkg::res_t res;
  logic           cmd_valid;
  logic           cmd_pop;

  csur_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csur_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  csur_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  // Drive result ports from the queue head
  assign out_kind       = res.out_kind;
  assign tx_byte        = res.tx_byte;
  assign sample_number  = res.sample_number;
  assign sample_index   = res.sample_index;
  assign sample_pulses  = res.sample_pulses;
  assign reported_count = res.reported_count;
  assign last           = res.last;

endmodule

// ----- rtl/core/csur_checker.sv -----
// ----------------------------------------------------------------------------
// csur_checker
// Port-level checks on the upload receiver, bound to the top level.
// ----------------------------------------------------------------------------
module csur_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_kind,
  input logic [7:0]  tx_byte,
  input logic [31:0] reported_count,
  input logic        last
);

  // Queue comes out of reset empty
  assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A request result always carries the request byte
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind == csur_pkg::KIND_REQ) |-> (tx_byte == csur_pkg::REQUEST_BYTE))
    else $error("request result without request byte");

  // Only samples may be flagged last
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind != csur_pkg::KIND_SAMPLE) |-> !last)
    else $error("last flag on a non-sample result");

  // A bad count is never zero
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind == csur_pkg::KIND_BADCNT) |-> (reported_count != 32'd0))
    else $error("bad-count result with zero count");

  // A waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(last)))
    else $error("waiting result changed before pop");

endmodule

bind counted_sample_upload_receiver csur_checker u_csur_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .pop            (pop),
  .out_kind       (out_kind),
  .tx_byte        (tx_byte),
  .reported_count (reported_count),
  .last           (last)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the counted sample upload receiver. A short table
// of requests walks the special cases, then random uploads run under six
// register settings. Every request pushed is fed to an in-bench model of the
// receiver; popped results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CLK_PERIOD        = 4;
  localparam int          RESET_CYCLES      = 11;
  localparam int          SETTLE_CYCLES     = 12;
  localparam int          HOLDOFF_CYCLES    = 80;
  localparam int          ITEMS_PER_SETTING = 171;
  localparam int unsigned CYCLE_LIMIT       = 3000000;
  localparam logic [1:0]  REQ_UNUSED        = 2'd3;

  typedef enum logic [1:0] {FR_IDLE, FR_COUNT, FR_SAMPLES} frame_phase_t;

  // One row of the directed table: a register write or a request
  typedef struct {
    bit             cfg_row;
    logic [1:0]     reg_idx;
    logic [31:0]    value;
    logic [1:0]     rq;
    bit             typed;
    csur_pkg::res_t want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  logic [1:0]                  req_type = csur_pkg::REQ_TICK;
  logic [7:0]                  rx_byte = 8'h00;
  logic                        pop = 1'b0;
  logic                        empty;
  logic [2:0]                  out_kind;
  logic [7:0]                  tx_byte;
  logic [11:0]                 sample_number;
  logic [15:0]                 sample_index;
  logic [15:0]                 sample_pulses;
  logic [31:0]                 reported_count;
  logic                        last;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [csur_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // Model of the receiver: registers and frame state
  csur_pkg::cfg_t      cfg = '{sample_format: csur_pkg::METHOD_RST,
                               max_samples: csur_pkg::MAX_SAMP_RST,
                               byte_timeout_ticks: csur_pkg::TIMEOUT_RST};
  frame_phase_t        ph = FR_IDLE;
  logic [31:0]         count_acc = '0;
  logic [1:0]          count_pos = '0;
  logic [31:0]         shift = '0;
  logic [1:0]          byte_pos = '0;
  logic [12:0]         samples_seen = '0;
  logic [15:0]         tick_count = '0;

  csur_pkg::res_t      pending_results[$];
  stim_row_t           dir_rows[$];

  int                  mismatches = 0;
  int                  results_checked = 0;
  int                  requests_sent = 0;
  int                  reg_writes = 0;
  int                  phase_left = 0;
  int                  send_idle_pct = 25;
  int                  recv_idle_pct = 46;
  int                  phase_no = 0;
  int                  held_phase = 0;
  int                  hold_left = 0;

  counted_sample_upload_receiver u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .req_type(req_type), .rx_byte(rx_byte),
    .pop(pop), .empty(empty), .out_kind(out_kind), .tx_byte(tx_byte),
    .sample_number(sample_number), .sample_index(sample_index),
    .sample_pulses(sample_pulses), .reported_count(reported_count), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Drop the frame and return to idle; the count and the samples seen are kept
  function automatic void clear_frame();
    ph = FR_IDLE;
    count_pos = '0;
    byte_pos = '0;
    shift = '0;
    tick_count = '0;
  endfunction

  // Advance the model by one request; return 1 when it yields a result
  function automatic bit predict_request(input logic [1:0] rq, input logic [7:0] b,
                                         output csur_pkg::res_t r);
    logic [12:0] cap;
    logic [1:0]  last_pos;
    logic [31:0] nxt;
    r = '0;
    case (rq)
      csur_pkg::REQ_START: begin
        clear_frame();
        ph = FR_COUNT;
        count_acc = '0;
        samples_seen = '0;
        r.out_kind = csur_pkg::KIND_REQ;
        r.tx_byte = csur_pkg::REQUEST_BYTE;
        return 1'b1;
      end
      csur_pkg::REQ_BYTE: begin
        if (ph == FR_IDLE) return 1'b0;
        tick_count = '0;
        if (ph == FR_COUNT) begin
          count_acc = {count_acc[23:0], b};
          count_pos = count_pos + 2'd1;
          if (count_pos != 2'd0) return 1'b0;
          cap = (cfg.max_samples > 13'(csur_pkg::MAX_SAMPLE_CAP)) ?
                13'(csur_pkg::MAX_SAMPLE_CAP) : cfg.max_samples;
          if (count_acc == 0) begin
            clear_frame();
            r.out_kind = csur_pkg::KIND_EMPTY;
            return 1'b1;
          end
          if (count_acc > cap) begin
            clear_frame();
            r.out_kind = csur_pkg::KIND_BADCNT;
            r.reported_count = count_acc;
            return 1'b1;
          end
          ph = FR_SAMPLES;
          samples_seen = '0;
          byte_pos = '0;
          shift = '0;
          return 1'b0;
        end
        // gather sample bytes; the format in force decides the size
        last_pos = cfg.sample_format ? 2'd2 : 2'd3;
        shift = {shift[23:0], b};
        if (byte_pos < last_pos) begin
          byte_pos = byte_pos + 2'd1;
          return 1'b0;
        end
        if (cfg.sample_format) begin
          r.sample_index = {6'd0, shift[23:14]};
          r.sample_pulses = {6'd0, shift[13:4]};
        end else begin
          r.sample_index = shift[31:16];
          r.sample_pulses = shift[15:0];
        end
        r.out_kind = csur_pkg::KIND_SAMPLE;
        r.sample_number = samples_seen[11:0];
        nxt = {19'd0, samples_seen} + 32'd1;
        r.last = (nxt >= count_acc);
        samples_seen = samples_seen + 13'd1;
        byte_pos = '0;
        shift = '0;
        if (r.last) clear_frame();
        return 1'b1;
      end
      csur_pkg::REQ_TICK: begin
        if (ph == FR_IDLE) return 1'b0;
        if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
        if (tick_count >= cfg.byte_timeout_ticks) begin
          clear_frame();
          r.out_kind = csur_pkg::KIND_TIMEOUT;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic csur_pkg::res_t mk_res(input logic [2:0] k, input logic [7:0] tx,
                                            input logic [11:0] num,
                                            input logic [15:0] idx,
                                            input logic [15:0] pul,
                                            input logic [31:0] cnt,
                                            input logic lst);
    csur_pkg::res_t r;
    r.out_kind = k;
    r.tx_byte = tx;
    r.sample_number = num;
    r.sample_index = idx;
    r.sample_pulses = pul;
    r.reported_count = cnt;
    r.last = lst;
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic [1:0] rq, input logic [7:0] b);
    stim_row_t s;
    s.cfg_row = 1'b0;
    s.reg_idx = csur_pkg::REG_METHOD;
    s.value = {24'd0, b};
    s.rq = rq;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t typed_row(input logic [1:0] rq, input logic [7:0] b,
                                          input csur_pkg::res_t want);
    stim_row_t s;
    s = req_row(rq, b);
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] v);
    stim_row_t s;
    s = req_row(csur_pkg::REQ_TICK, 8'h00);
    s.cfg_row = 1'b1;
    s.reg_idx = idx;
    s.value = v;
    return s;
  endfunction

  // Mostly random bytes, with the extremes now and then
  function automatic logic [7:0] pick_byte();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(9) == 0) return (v[8] ? 8'hFF : 8'h00);
    return v[7:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_checked, what,
             got, want);
    mismatches++;
  endtask

  // Offer one request, hold it until accepted, then record its expectation
  task automatic send_item(input logic [1:0] rq, input logic [7:0] b, input bit typed,
                           input csur_pkg::res_t want);
    csur_pkg::res_t r;
    bit             hit;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    hit = predict_request(rq, b, r);
    if (typed) r = want;
    if (hit || typed) pending_results.push_back(r);
    requests_sent++;
  endtask

  // Random requests count against the budget of the current setting
  task automatic offer(input logic [1:0] rq, input logic [7:0] b);
    if (phase_left > 0) begin
      phase_left--;
      send_item(rq, b, 1'b0, '0);
    end
  endtask

  // Wait until every result is out and the request queue has run dry
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    logic [31:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      csur_pkg::REG_METHOD: begin
        cfg.sample_format = v[0];
        mask = 32'h0000_0001;
      end
      csur_pkg::REG_MAX_SAMP: begin
        cfg.max_samples = v[12:0];
        mask = 32'h0000_1FFF;
      end
      csur_pkg::REG_TIMEOUT: begin
        cfg.byte_timeout_ticks = v[15:0];
        mask = 32'h0000_FFFF;
      end
      default: mask = 32'h0;
    endcase
    if (prdata !== (v & mask)) report_mismatch("register read", prdata, v & mask);
    reg_writes++;
  endtask

  // Occasional ticks before a byte, short of the timeout where it allows
  task automatic stray_ticks();
    int n;
    if (cfg.byte_timeout_ticks >= 2 && $urandom_range(99) < 15) begin
      n = (cfg.byte_timeout_ticks > 4) ? 3 : cfg.byte_timeout_ticks - 1;
      repeat ($urandom_range(1, n)) offer(csur_pkg::REQ_TICK, pick_byte());
    end else if ($urandom_range(99) < 3) begin
      offer(csur_pkg::REQ_TICK, pick_byte());
    end
  endtask

  // One upload with random content, or a single stray request
  task automatic random_episode();
    logic [31:0] cnt;
    int          cap;
    int          nsamp;
    int          per;
    int          sel;
    cap = cfg.max_samples;
    if (cap > csur_pkg::MAX_SAMPLE_CAP) cap = csur_pkg::MAX_SAMPLE_CAP;
    if ($urandom_range(99) < 8) begin
      sel = $urandom_range(2);
      if (sel == 0) offer(csur_pkg::REQ_BYTE, pick_byte());
      else if (sel == 1) offer(csur_pkg::REQ_TICK, pick_byte());
      else offer(REQ_UNUSED, pick_byte());
      return;
    end
    offer(csur_pkg::REQ_START, pick_byte());
    sel = $urandom_range(99);
    if (sel < 10) cnt = 0;
    else if (sel < 20) cnt = cap;
    else if (sel < 30) cnt = cap + 1;
    else if (sel < 38) cnt = $urandom;
    else if (cap == 0) cnt = 1;
    else cnt = $urandom_range(1, (cap < 6) ? cap : 6);
    for (int i = 0; i < 4; i++) begin
      stray_ticks();
      offer(csur_pkg::REQ_BYTE, cnt[31 - 8 * i -: 8]);
    end
    if (cnt != 0 && cnt <= cap) begin
      nsamp = (cnt > 8) ? $urandom_range(1, 8) : cnt;
      if ($urandom_range(9) == 0) nsamp = $urandom_range(0, nsamp - 1);
      per = cfg.sample_format ? 3 : 4;
      repeat (nsamp * per) begin
        stray_ticks();
        offer(csur_pkg::REQ_BYTE, pick_byte());
      end
    end
    // run out the byte timer now and then
    if ($urandom_range(9) == 0 && cfg.byte_timeout_ticks <= 300)
      repeat ((cfg.byte_timeout_ticks == 0) ? 1 : cfg.byte_timeout_ticks)
        offer(csur_pkg::REQ_TICK, pick_byte());
  endtask

  // Apply one register setting and run random uploads under it
  task automatic run_setting(input logic m, input logic [12:0] mx, input logic [15:0] t,
                             input int mode);
    settle();
    write_reg(csur_pkg::REG_METHOD, {31'd0, m});
    write_reg(csur_pkg::REG_MAX_SAMP, {19'd0, mx});
    write_reg(csur_pkg::REG_TIMEOUT, {16'd0, t});
    case (mode)
      0: begin
        send_idle_pct = 25;
        recv_idle_pct = 46;
      end
      1: begin
        send_idle_pct = 46;
        recv_idle_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    phase_no <= phase_no + 1;
    phase_left = ITEMS_PER_SETTING;
    while (phase_left > 0) random_episode();
  endtask

  // Compare the oldest expectation with the result on the ports
  task automatic check_result();
    csur_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none pending, out_kind", out_kind, 0);
      return;
    end
    want = pending_results.pop_front();
    if (out_kind !== want.out_kind) report_mismatch("out_kind", out_kind, want.out_kind);
    if (tx_byte !== want.tx_byte) report_mismatch("tx_byte", tx_byte, want.tx_byte);
    if (sample_number !== want.sample_number)
      report_mismatch("sample_number", sample_number, want.sample_number);
    if (sample_index !== want.sample_index)
      report_mismatch("sample_index", sample_index, want.sample_index);
    if (sample_pulses !== want.sample_pulses)
      report_mismatch("sample_pulses", sample_pulses, want.sample_pulses);
    if (reported_count !== want.reported_count)
      report_mismatch("reported_count", reported_count, want.reported_count);
    if (last !== want.last) report_mismatch("last", last, want.last);
    results_checked++;
  endtask

  // Result side: pop at random, with one long hold-off per setting
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (pop && !empty) check_result();
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (phase_no != held_phase) begin
        held_phase = phase_no;
        hold_left = HOLDOFF_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cycle limit of %0d reached with %0d results pending", CYCLE_LIMIT,
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : request_side
    // dropped while idle, unknown request, empty upload, samples, restart
    dir_rows.push_back(req_row(csur_pkg::REQ_BYTE, 8'hFF));
    dir_rows.push_back(req_row(csur_pkg::REQ_TICK, 8'h00));
    dir_rows.push_back(req_row(REQ_UNUSED, 8'h5A));
    dir_rows.push_back(typed_row(csur_pkg::REQ_START, 8'h00,
                                 mk_res(csur_pkg::KIND_REQ, csur_pkg::REQUEST_BYTE,
                                        0, 0, 0, 0, 0)));
    repeat (3) dir_rows.push_back(req_row(csur_pkg::REQ_BYTE, 8'h00));
    dir_rows.push_back(typed_row(csur_pkg::REQ_BYTE, 8'h00,
                                 mk_res(csur_pkg::KIND_EMPTY, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(typed_row(csur_pkg::REQ_START, 8'hFF,
                                 mk_res(csur_pkg::KIND_REQ, csur_pkg::REQUEST_BYTE,
                                        0, 0, 0, 0, 0)));
    repeat (3) dir_rows.push_back(req_row(csur_pkg::REQ_BYTE, 8'h00));
    dir_rows.push_back(req_row(csur_pkg::REQ_BYTE, 8'h02));
    repeat (2) dir_rows.push_back(req_row(csur_pkg::REQ_BYTE, 8'hFF));
    dir_rows.push_back(typed_row(csur_pkg::REQ_BYTE, 8'hFF,
                                 mk_res(csur_pkg::KIND_SAMPLE, 0, 0, 16'h03FF, 16'h03FF,
                                        0, 0)));
    dir_rows.push_back(req_row(csur_pkg::REQ_TICK, 8'h00));
    dir_rows.push_back(typed_row(csur_pkg::REQ_START, 8'h00,
                                 mk_res(csur_pkg::KIND_REQ, csur_pkg::REQUEST_BYTE,
                                        0, 0, 0, 0, 0)));
    // zero timeout: the first tick ends the exchange
    dir_rows.push_back(reg_row(csur_pkg::REG_TIMEOUT, 32'd0));
    dir_rows.push_back(typed_row(csur_pkg::REQ_TICK, 8'h00,
                                 mk_res(csur_pkg::KIND_TIMEOUT, 0, 0, 0, 0, 0, 0)));
    // zero cap: any nonzero count is refused
    dir_rows.push_back(reg_row(csur_pkg::REG_MAX_SAMP, 32'd0));
    dir_rows.push_back(typed_row(csur_pkg::REQ_START, 8'h00,
                                 mk_res(csur_pkg::KIND_REQ, csur_pkg::REQUEST_BYTE,
                                        0, 0, 0, 0, 0)));
    repeat (3) dir_rows.push_back(req_row(csur_pkg::REQ_BYTE, 8'hFF));
    dir_rows.push_back(typed_row(csur_pkg::REQ_BYTE, 8'hFF,
                                 mk_res(csur_pkg::KIND_BADCNT, 0, 0, 0, 0,
                                        32'hFFFF_FFFF, 0)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].rq, dir_rows[i].value[7:0], dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    run_setting(1'b1, 13'd4096, 16'd200, 0);
    run_setting(1'b0, 13'd5, 16'd3, 0);
    run_setting(1'b1, 13'd8191, 16'd1, 1);
    run_setting(1'b0, 13'd1, 16'd0, 1);
    run_setting(1'b1, 13'd0, 16'd2, 2);
    run_setting(1'b0, 13'd4096, 16'd65535, 2);

    // drain and let the tail of the request queue run out
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);

    $display("ran %0d requests and checked %0d results over %0d register writes",
             requests_sent, results_checked, reg_writes);
    $display("both sample formats, caps 0 to 8191, timeouts 0 to 65535, long stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/csur_pkg.sv
rtl/core/csur_regs.sv
rtl/core/csur_front.sv
rtl/core/csur_back.sv
rtl/core/counted_sample_upload_receiver.sv
rtl/core/csur_checker.sv
sim/tb.sv
